/* rtl/mdt_pkg.sv */
// ----------------------------------------------------------------------------
// mdt_pkg: shared types, codes and character classes
// Token record, queue entry, scanner mode codes and byte tests used by the
// scanner front end, the token queue and the output stage.
// ----------------------------------------------------------------------------
package mdt_pkg;

	// byte offset counter width (internal); token_start reports the low 32 bits
	localparam int POS_BITS   = 32;
	localparam int START_W    = 32;
	localparam int VALUE_W    = 31;
	localparam int LEN_W      = 8;
	localparam int KIND_W     = 4;

	// token queue depth, must be a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [VALUE_W-1:0] NUM_MAX = '1;
	localparam logic [LEN_W-1:0]   LEN_MAX = '1;

	// scanner modes
	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_SLASH  = 3'd3;
	localparam logic [2:0] MODE_LINE   = 3'd4;
	localparam logic [2:0] MODE_BLOCK  = 3'd5;
	localparam logic [2:0] MODE_BSTAR  = 3'd6;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_EOF     = 4'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 4'd1;
	localparam logic [KIND_W-1:0] KIND_KW_MAT  = 4'd2;
	localparam logic [KIND_W-1:0] KIND_KW_MUL  = 4'd3;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 4'd4;
	localparam logic [KIND_W-1:0] KIND_STAR    = 4'd5;
	localparam logic [KIND_W-1:0] KIND_SEMI    = 4'd6;
	localparam logic [KIND_W-1:0] KIND_COMMA   = 4'd7;
	localparam logic [KIND_W-1:0] KIND_LPAREN  = 4'd8;
	localparam logic [KIND_W-1:0] KIND_RPAREN  = 4'd9;
	localparam logic [KIND_W-1:0] KIND_LBRACK  = 4'd10;
	localparam logic [KIND_W-1:0] KIND_RBRACK  = 4'd11;
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 4'd12;

	// characters of interest
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic               ovf;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic [7:0]         ub;
	} token_t;

	// one queue entry: the tokens caused by one input transfer
	typedef struct packed {
		logic   two;
		token_t t0;
		token_t t1;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A]}) || (c == CH_UNDER);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};
	endfunction

	// letters of "matrix" by position
	function automatic logic [7:0] kw_mat_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h6D;
			3'd1: r = 8'h61;
			3'd2: r = 8'h74;
			3'd3: r = 8'h72;
			3'd4: r = 8'h69;
			3'd5: r = 8'h78;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// letters of "multiply" by position
	function automatic logic [7:0] kw_mul_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = 8'h6D;
			3'd1: r = 8'h75;
			3'd2: r = 8'h6C;
			3'd3: r = 8'h74;
			3'd4: r = 8'h69;
			3'd5: r = 8'h70;
			3'd6: r = 8'h6C;
			3'd7: r = 8'h79;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// single-byte punctuation; anything else is unknown
	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_STAR:   k = KIND_STAR;
			CH_SEMI:   k = KIND_SEMI;
			CH_COMMA:  k = KIND_COMMA;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_LBRACK: k = KIND_LBRACK;
			CH_RBRACK: k = KIND_RBRACK;
			default:   k = KIND_UNKNOWN;
		endcase
		return k;
	endfunction

endpackage

/* rtl/mdt_front.sv */
// ----------------------------------------------------------------------------
// mdt_front: byte scanner
// Accepts one byte or end marker per transfer, tracks the scan mode and the
// pending run, and pushes the one or two tokens it causes, if any, as one entry.
// ----------------------------------------------------------------------------
module mdt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [7:0]           char_code,
	input  logic                 end_of_input,
	output logic                 push,
	output mdt_pkg::entry_t      push_entry
);
	import mdt_pkg::*;

	logic [2:0]          mode_q;
	logic [POS_BITS-1:0] pos_q;
	logic [VALUE_W-1:0]  acc_q;
	logic                ovf_q;
	logic [POS_BITS-1:0] start_q;
	logic [LEN_W-1:0]    len_q;
	logic [1:0]          alive_q;

	logic [2:0]          mode_n;
	logic [POS_BITS-1:0] pos_n;
	logic [VALUE_W-1:0]  acc_n;
	logic                ovf_n;
	logic [POS_BITS-1:0] start_n;
	logic [LEN_W-1:0]    len_n;
	logic [1:0]          alive_n;

	logic    flush_v, second_v, do_idle, run_mode;
	token_t  flush_tok, second_tok;
	logic    mat_ok, mul_ok;
	logic [LEN_W-1:0] len_inc;
	logic [34:0] num_mul, num_sum;
	logic [POS_BITS-1:0] pos_inc;

	// per-byte helpers
	assign len_inc  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
	assign mat_ok   = (len_q < LEN_W'(6)) && (char_code == kw_mat_char(len_q[2:0]));
	assign mul_ok   = (len_q < LEN_W'(8)) && (char_code == kw_mul_char(len_q[2:0]));
	assign num_mul  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
	assign num_sum  = num_mul + {31'd0, char_code[3:0]};
	assign pos_inc  = pos_q + {{(POS_BITS-1){1'b0}}, 1'b1};
	assign run_mode = (mode_q == MODE_IDENT) || (mode_q == MODE_NUMBER) ||
	                  (mode_q == MODE_SLASH);

	// token that closes the pending run
	always_comb begin
		flush_tok       = '0;
		flush_tok.start = START_W'(start_q);
		flush_tok.len   = len_q;
		case (mode_q)
			MODE_IDENT: begin
				if (alive_q[0] && len_q == LEN_W'(6))
					flush_tok.kind = KIND_KW_MAT;
				else if (alive_q[1] && len_q == LEN_W'(8))
					flush_tok.kind = KIND_KW_MUL;
				else
					flush_tok.kind = KIND_IDENT;
			end
			MODE_NUMBER: begin
				flush_tok.kind  = KIND_NUMBER;
				flush_tok.value = acc_q;
				flush_tok.ovf   = ovf_q;
			end
			default: begin
				flush_tok.kind = KIND_UNKNOWN;
				flush_tok.len  = LEN_W'(1);
				flush_tok.ub   = CH_SLASH;
			end
		endcase
	end

	// next state and emitted tokens
	always_comb begin
		mode_n     = mode_q;
		pos_n      = pos_inc;
		acc_n      = acc_q;
		ovf_n      = ovf_q;
		start_n    = start_q;
		len_n      = len_q;
		alive_n    = alive_q;
		flush_v    = 1'b0;
		second_v   = 1'b0;
		do_idle    = 1'b0;
		second_tok = '0;

		if (end_of_input) begin
			flush_v          = run_mode;
			second_v         = 1'b1;
			second_tok.kind  = KIND_EOF;
			second_tok.start = START_W'(pos_q);
			mode_n           = MODE_IDLE;
			pos_n            = '0;
		end else begin
			case (mode_q)
				MODE_IDENT: begin
					if (is_alpha(char_code) || is_digit(char_code)) begin
						alive_n = alive_q & {mul_ok, mat_ok};
						len_n   = len_inc;
					end else begin
						flush_v = 1'b1;
						do_idle = 1'b1;
					end
				end
				MODE_NUMBER: begin
					if (is_digit(char_code)) begin
						if (num_sum > {4'd0, NUM_MAX}) begin
							acc_n = NUM_MAX;
							ovf_n = 1'b1;
						end else begin
							acc_n = num_sum[VALUE_W-1:0];
						end
						len_n = len_inc;
					end else begin
						flush_v = 1'b1;
						do_idle = 1'b1;
					end
				end
				MODE_SLASH: begin
					if (char_code == CH_SLASH)
						mode_n = MODE_LINE;
					else if (char_code == CH_STAR)
						mode_n = MODE_BLOCK;
					else begin
						flush_v = 1'b1;
						do_idle = 1'b1;
					end
				end
				MODE_LINE: begin
					if (char_code == CH_LF)
						mode_n = MODE_IDLE;
				end
				MODE_BLOCK: begin
					if (char_code == CH_STAR)
						mode_n = MODE_BSTAR;
				end
				MODE_BSTAR: begin
					if (char_code == CH_SLASH)
						mode_n = MODE_IDLE;
					else if (char_code != CH_STAR)
						mode_n = MODE_BLOCK;
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase

			// byte seen from idle: start a run, skip a blank or emit a one-byte token
			if (do_idle) begin
				mode_n = MODE_IDLE;
				if (is_blank(char_code)) begin
					mode_n = MODE_IDLE;
				end else if (char_code == CH_SLASH) begin
					mode_n  = MODE_SLASH;
					start_n = pos_q;
				end else if (is_alpha(char_code)) begin
					mode_n  = MODE_IDENT;
					start_n = pos_q;
					len_n   = LEN_W'(1);
					alive_n = (char_code == kw_mat_char(3'd0)) ? 2'b11 : 2'b00;
				end else if (is_digit(char_code)) begin
					mode_n  = MODE_NUMBER;
					start_n = pos_q;
					len_n   = LEN_W'(1);
					acc_n   = {27'd0, char_code[3:0]};
					ovf_n   = 1'b0;
				end else begin
					second_v         = 1'b1;
					second_tok.kind  = punct_kind(char_code);
					second_tok.start = START_W'(pos_q);
					second_tok.len   = LEN_W'(1);
					second_tok.ub    = (punct_kind(char_code) == KIND_UNKNOWN) ?
					                   char_code : 8'd0;
				end
			end
		end
	end

	// queue entry
	assign push           = in_fire && (flush_v || second_v);
	assign push_entry.two = flush_v && second_v;
	assign push_entry.t0  = flush_v ? flush_tok : second_tok;
	assign push_entry.t1  = second_tok;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			start_q <= '0;
			len_q   <= '0;
			alive_q <= 2'b11;
		end else if (in_fire) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			start_q <= start_n;
			len_q   <= len_n;
			alive_q <= alive_n;
		end
	end

endmodule

/* rtl/mdt_fifo.sv */
// ----------------------------------------------------------------------------
// mdt_fifo: token queue
// Short queue of entries between the scanner and the output stage, so either
// side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
module mdt_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mdt_pkg::entry_t      wr_entry,
	input  logic                 pop,
	output mdt_pkg::entry_t      rd_entry,
	output mdt_pkg::fifo_stat_t  stat
);
	import mdt_pkg::*;

	entry_t             mem_q [FIFO_DEPTH];
	entry_t             rd_entry_q;
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW-1:0] rd_next;
	logic [FIFO_AW:0]   count_q;
	logic               do_push, do_pop;

	assign stat.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_next    = do_pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
	assign rd_entry   = rd_entry_q;

	// storage; head entry registered, a write to the next head is passed through
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_entry;
		if (do_push && (wr_ptr_q == rd_next))
			rd_entry_q <= wr_entry;
		else
			rd_entry_q <= mem_q[rd_next];
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (do_push && !do_pop)
				count_q <= count_q + (FIFO_AW+1)'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - (FIFO_AW+1)'(1);
		end
	end

endmodule

/* rtl/mdt_back.sv */
// ----------------------------------------------------------------------------
// mdt_back: token output stage
// Takes one queue entry at a time into its output register and presents its
// one or two tokens in order, marking the final one with last.
// ----------------------------------------------------------------------------
module mdt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 entry_valid,
	input  mdt_pkg::entry_t      entry,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mdt_pkg::token_t      out_tok,
	output logic                 out_last
);
	import mdt_pkg::*;

	entry_t ent_q;
	logic   hold_q;
	logic   sel_q;
	logic   out_fire, done;

	assign out_fire  = hold_q && out_ready;
	assign done      = sel_q || !ent_q.two;
	assign pop       = entry_valid && (!hold_q || (out_fire && done));
	assign out_valid = hold_q;
	assign out_tok   = sel_q ? ent_q.t1 : ent_q.t0;
	assign out_last  = done;

	// entry payload
	always_ff @(posedge clk) begin
		if (pop)
			ent_q <= entry;
	end

	// occupancy and token select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
			sel_q  <= 1'b0;
		end else if (pop) begin
			hold_q <= 1'b1;
			sel_q  <= 1'b0;
		end else if (out_fire) begin
			if (done)
				hold_q <= 1'b0;
			else
				sel_q <= 1'b1;
		end
	end

endmodule

/* rtl/matrix_dsl_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// matrix_dsl_tokenizer_unit: streaming lexer for a small matrix language
// One source byte or end marker per input transfer, tokens out with start
// offset, length, number value and offending byte.
// ----------------------------------------------------------------------------
// Throughput: one input byte per cycle while the queue is not full; one token
//   per cycle at the output while m_axis_tready is high. A token passes from
//   the scanner -> 4-entry queue (registered head) -> output register.
// A byte causing two tokens holds the output register for two transfers; the
//   queue absorbs the difference and s_axis_tready drops only when it is full.
// Reset (arst_n low): scanner idle at offset 0, queue and output emptied.
// ----------------------------------------------------------------------------
module matrix_dsl_tokenizer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	input  logic [0:0]  s_axis_tuser,   // [0] end_of_input
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [30:0] number_value, [31] number_overflow,
	                                    // [63:32] token_start, [71:64] token_length,
	                                    // [79:72] unknown_byte
	output logic [3:0]  m_axis_tuser,   // [3:0] token_kind
	output logic        m_axis_tlast
);
	import mdt_pkg::*;

	logic       in_fire;
	logic       push, pop;
	entry_t     push_entry, head_entry;
	fifo_stat_t fstat;
	token_t     out_tok;

	assign s_axis_tready = !fstat.full;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	mdt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_fire      (in_fire),
		.char_code    (s_axis_tdata),
		.end_of_input (s_axis_tuser[0]),
		.push         (push),
		.push_entry   (push_entry)
	);

	mdt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (push_entry),
		.pop      (pop),
		.rd_entry (head_entry),
		.stat     (fstat)
	);

	mdt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (!fstat.empty),
		.entry       (head_entry),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_tok     (out_tok),
		.out_last    (m_axis_tlast)
	);

	// output packing
	assign m_axis_tuser = out_tok.kind;
	assign m_axis_tdata = {out_tok.ub, out_tok.len, out_tok.start,
	                       out_tok.ovf, out_tok.value};

endmodule

/* rtl/mdt_checker.sv */
// ----------------------------------------------------------------------------
// mdt_checker: port-level checks for the tokenizer
// Watches the output stream for held payloads and per-kind field rules.
// ----------------------------------------------------------------------------
module mdt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [79:0] m_axis_tdata,
	input logic [3:0]  m_axis_tuser,
	input logic        m_axis_tlast
);
	import mdt_pkg::*;

	// stalled token stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
		$stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output token changed while stalled");

	// eof closes the response and has no length
	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == KIND_EOF |->
		m_axis_tlast && m_axis_tdata[71:64] == 8'd0)
		else $error("eof token without last or with nonzero length");

	// value and overflow only on numbers
	a_num_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_NUMBER |-> m_axis_tdata[31:0] == 32'd0)
		else $error("number fields set on non-number token");

	// offending byte only on unknown tokens
	a_unknown_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != KIND_UNKNOWN |-> m_axis_tdata[79:72] == 8'd0)
		else $error("unknown byte set on known token");

endmodule

bind matrix_dsl_tokenizer_unit mdt_checker u_mdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

/* tb/matrix_dsl_tokenizer_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_dsl_tokenizer_unit_tb: self-checking bench for the streaming lexer
// Feeds directed and random source text through s_axis, predicts every token
// in a scoreboard class and compares each m_axis transfer field by field.
// Both sides idle at random, the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module matrix_dsl_tokenizer_unit_tb;
	import mdt_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int STIM_TARGET    = 1230;
	localparam int HOLD_CYCLES    = 240;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
	logic [0:0]  s_axis_tuser = 1'b0;    // [0] end_of_input
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;           // [30:0] number_value, [31] number_overflow,
	                                     // [63:32] token_start, [71:64] token_length,
	                                     // [79:72] unknown_byte
	logic [3:0]  m_axis_tuser;           // [3:0] token_kind
	logic        m_axis_tlast;

	matrix_dsl_tokenizer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	typedef struct packed {
		token_t tok;
		logic   last;
	} expected_tok_t;

	typedef struct packed {
		logic [7:0] c;
		logic       eoi;
	} src_item_t;

	// ------------------------------------------------------------------------
	// Token predictor and result checker
	// ------------------------------------------------------------------------
	class token_scoreboard;
		logic [2:0]  scan;
		logic [31:0] pos;
		logic [30:0] acc;
		logic        acc_sat;
		logic [31:0] tok_start;
		logic [7:0]  run_len;
		logic [1:0]  kw_alive;

		expected_tok_t pending[$];
		expected_tok_t fresh[$];
		int mismatches;
		int inputs_seen;
		int tokens_seen;
		int kind_count[16];

		function new();
			scan = MODE_IDLE;
			pos = '0;
			acc = '0;
			acc_sat = 1'b0;
			tok_start = '0;
			run_len = '0;
			kw_alive = 2'b11;
			mismatches = 0;
			inputs_seen = 0;
			tokens_seen = 0;
			foreach (kind_count[i]) kind_count[i] = 0;
		endfunction

		function bit letter_byte(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
		endfunction

		function bit digit_byte(logic [7:0] c);
			return c >= "0" && c <= "9";
		endfunction

		function void push_token(logic [3:0] kind, logic [30:0] value, logic sat,
				logic [31:0] at, logic [7:0] len, logic [7:0] ub);
			expected_tok_t t;
			t.tok.kind  = kind;
			t.tok.value = value;
			t.tok.ovf   = sat;
			t.tok.start = at;
			t.tok.len   = len;
			t.tok.ub    = ub;
			t.last      = 1'b0;
			fresh.push_back(t);
		endfunction

		// keyword candidates die on the first letter that does not match
		function void ident_byte(logic [7:0] c);
			string mat;
			string mul;
			mat = "matrix";
			mul = "multiply";
			if (!(run_len < 8'd6 && c == mat[run_len])) kw_alive[0] = 1'b0;
			if (!(run_len < 8'd8 && c == mul[run_len])) kw_alive[1] = 1'b0;
			if (run_len != LEN_MAX) run_len++;
		endfunction

		// close an identifier, number or held slash
		function void flush_run();
			logic [3:0] k;
			case (scan)
				MODE_IDENT: begin
					k = KIND_IDENT;
					if (kw_alive[0] && run_len == 8'd6) k = KIND_KW_MAT;
					else if (kw_alive[1] && run_len == 8'd8) k = KIND_KW_MUL;
					push_token(k, '0, 1'b0, tok_start, run_len, 8'h00);
				end
				MODE_NUMBER: push_token(KIND_NUMBER, acc, acc_sat, tok_start, run_len, 8'h00);
				MODE_SLASH:  push_token(KIND_UNKNOWN, '0, 1'b0, tok_start, 8'd1, CH_SLASH);
				default: ;
			endcase
			scan = MODE_IDLE;
		endfunction

		// a byte seen while no token is open
		function void open_token(logic [7:0] c);
			logic [3:0] k;
			if (c inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) return;
			if (c == CH_SLASH) begin
				scan = MODE_SLASH;
				tok_start = pos;
			end else if (letter_byte(c)) begin
				scan = MODE_IDENT;
				tok_start = pos;
				run_len = '0;
				kw_alive = 2'b11;
				ident_byte(c);
			end else if (digit_byte(c)) begin
				scan = MODE_NUMBER;
				tok_start = pos;
				run_len = 8'd1;
				acc = 31'(c - 8'h30);
				acc_sat = 1'b0;
			end else begin
				case (c)
					CH_STAR:   k = KIND_STAR;
					CH_SEMI:   k = KIND_SEMI;
					CH_COMMA:  k = KIND_COMMA;
					CH_LPAREN: k = KIND_LPAREN;
					CH_RPAREN: k = KIND_RPAREN;
					CH_LBRACK: k = KIND_LBRACK;
					CH_RBRACK: k = KIND_RBRACK;
					default:   k = KIND_UNKNOWN;
				endcase
				push_token(k, '0, 1'b0, pos, 8'd1, (k == KIND_UNKNOWN) ? c : 8'h00);
			end
		endfunction

		// one accepted input transfer: advance the scanner, queue its tokens
		function void note_input(logic [7:0] c, logic eoi);
			longint unsigned v;
			expected_tok_t t;
			fresh.delete();
			inputs_seen++;
			if (eoi) begin
				if (scan inside {MODE_IDENT, MODE_NUMBER, MODE_SLASH}) flush_run();
				push_token(KIND_EOF, '0, 1'b0, pos, 8'd0, 8'h00);
				scan = MODE_IDLE;
				pos = '0;
			end else begin
				case (scan)
					MODE_IDENT: begin
						if (letter_byte(c) || digit_byte(c)) ident_byte(c);
						else begin
							flush_run();
							open_token(c);
						end
					end
					MODE_NUMBER: begin
						if (digit_byte(c)) begin
							v = 64'(acc) * 64'd10 + 64'(c) - 64'h30;
							if (v > 64'(NUM_MAX)) begin
								v = 64'(NUM_MAX);
								acc_sat = 1'b1;
							end
							acc = 31'(v);
							if (run_len != LEN_MAX) run_len++;
						end else begin
							flush_run();
							open_token(c);
						end
					end
					MODE_SLASH: begin
						if (c == CH_SLASH) scan = MODE_LINE;
						else if (c == CH_STAR) scan = MODE_BLOCK;
						else begin
							flush_run();
							open_token(c);
						end
					end
					MODE_LINE:  if (c == CH_LF) scan = MODE_IDLE;
					MODE_BLOCK: if (c == CH_STAR) scan = MODE_BSTAR;
					MODE_BSTAR: begin
						if (c == CH_SLASH) scan = MODE_IDLE;
						else if (c != CH_STAR) scan = MODE_BLOCK;
					end
					default: begin
						scan = MODE_IDLE;
						open_token(c);
					end
				endcase
				pos = pos + 32'd1;
			end
			if (fresh.size() > 0) begin
				t = fresh.pop_back();
				t.last = 1'b1;
				fresh.push_back(t);
			end
			foreach (fresh[i]) pending.push_back(fresh[i]);
		endfunction

		function void field_check(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: token %0d %s mismatch, expected %0h, actual %0h",
					$time, tokens_seen, name, want, got);
				mismatches++;
			end
		endfunction

		// one accepted output transfer against the oldest expected token
		function void check_result(logic [79:0] data, logic [3:0] kind, logic last);
			expected_tok_t e;
			if (pending.size() == 0) begin
				$display("%0t: token with no expectation, expected none, actual kind %0d start %0h",
					$time, kind, data[63:32]);
				mismatches++;
				return;
			end
			e = pending.pop_front();
			tokens_seen++;
			kind_count[e.tok.kind]++;
			field_check("token_kind",      32'(e.tok.kind),  32'(kind));
			field_check("number_value",    32'(e.tok.value), 32'(data[30:0]));
			field_check("number_overflow", 32'(e.tok.ovf),   32'(data[31]));
			field_check("token_start",     e.tok.start,      data[63:32]);
			field_check("token_length",    32'(e.tok.len),   32'(data[71:64]));
			field_check("unknown_byte",    32'(e.tok.ub),    32'(data[79:72]));
			field_check("tlast",           32'(e.last),      32'(last));
		endfunction
	endclass

	token_scoreboard sb = new();

	// ------------------------------------------------------------------------
	// Source text generation
	// ------------------------------------------------------------------------
	src_item_t stim[$];
	int        n_sources = 0;
	bit        hold_done = 1'b0;

	string WORD_HEAD  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string WORD_CHARS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string DIGITS     = "0123456789";
	string PUNCT      = "*;,()[]";
	string BLANKS     = " \t\r\n";
	string ODD_ASCII  = "+-=#@!$%&.<>?{}|~^`:\"'\\";
	string BLOCK_BODY = "**//ab \n";
	string near_keywords[13] = '{"matrix", "multiply", "matri", "matrixx", "multipl",
		"multiplyy", "Matrix", "m", "mu", "mat", "multiply_", "matrix9", "mul"};

	function automatic logic [7:0] pick_char(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic void add_byte(logic [7:0] c);
		src_item_t it;
		it.c = c;
		it.eoi = 1'b0;
		stim.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	// end marker; its data byte is don't-care, so randomize it
	function automatic void add_end();
		src_item_t it;
		it.c = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		stim.push_back(it);
		n_sources++;
	endfunction

	// one random source: mostly plausible tokens, some noise, then the end marker
	function automatic void gen_source(int idx);
		int pick;
		logic [7:0] b;
		// a few overlong tokens to hit length saturation
		if (idx == 3) begin
			add_text("matrix");
			repeat (294) add_byte(pick_char(WORD_CHARS));
			add_byte(CH_SPACE);
		end
		if (idx == 8) begin
			repeat (257) add_byte(pick_char(DIGITS));
			add_byte(CH_SEMI);
		end
		if (idx == 12) begin
			add_text("multiply");
			repeat (248) add_byte(pick_char(WORD_CHARS));
			add_byte(CH_COMMA);
		end
		repeat ($urandom_range(3, 14)) begin
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				add_byte(pick_char(WORD_HEAD));
				repeat ($urandom_range(0, 9)) add_byte(pick_char(WORD_CHARS));
			end else if (pick < 30) begin
				add_text(near_keywords[$urandom_range(0, 12)]);
			end else if (pick < 44) begin
				case ($urandom_range(0, 9))
					0: add_text("2147483647");
					1: add_text("2147483648");
					2: add_text("0");
					3: add_text("99999999999");
					default: repeat ($urandom_range(1, 12)) add_byte(pick_char(DIGITS));
				endcase
			end else if (pick < 62) begin
				add_byte(pick_char(PUNCT));
			end else if (pick < 69) begin
				add_text("//");
				repeat ($urandom_range(0, 8)) begin
					b = 8'($urandom_range(0, 255));
					add_byte((b == CH_LF) ? CH_SPACE : b);
				end
				add_byte(CH_LF);
			end else if (pick < 77) begin
				add_text("/*");
				repeat ($urandom_range(0, 8)) add_byte(pick_char(BLOCK_BODY));
				add_text("*/");
			end else if (pick < 82) begin
				add_byte(CH_SLASH);
			end else if (pick < 90) begin
				case ($urandom_range(0, 2))
					0: add_byte(8'h00);
					1: add_byte(8'($urandom_range(128, 255)));
					default: add_byte(pick_char(ODD_ASCII));
				endcase
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 9) < 7) add_byte(pick_char(BLANKS));
		end
		// tail: unterminated comments or a held slash at the end marker
		case ($urandom_range(0, 9))
			0: add_text("//tail");
			1: add_text("/*tail*");
			2: add_byte(CH_SLASH);
			default: ;
		endcase
		add_end();
	endfunction

	// stretch of the run where neither side idles
	function automatic bit calm_window();
		return sb.inputs_seen >= 700 && sb.inputs_seen < 900;
	endfunction

	// ------------------------------------------------------------------------
	// Input side driver
	// ------------------------------------------------------------------------
	task automatic send_item(input src_item_t it);
		if (!calm_window() && $urandom_range(0, 99) < 11) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom_range(0, 255));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= it.c;
		s_axis_tuser  <= it.eoi;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it.c, it.eoi);
	endtask

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// output side: check transfers, random backpressure, one long hold-off
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (!hold_done && sb.inputs_seen >= 400) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm_window() || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	// watchdog: ends the run after too many cycles with no transfer anywhere
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog expired, %0d tokens still expected", $time, sb.pending.size());
		$display("matrix_dsl_tokenizer_unit_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		int src_idx;
		// directed: all punctuation, lone slash, both comment kinds, block
		// close that must skip the opening star, number then letter, bytes
		// 0 and 255, held slash at the end, unterminated block comment
		add_text("*;,()[]/x//c\n/*/*/9a");
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(CH_SLASH);
		add_end();
		add_text("/*");
		add_end();

		src_idx = 0;
		while (stim.size() < STIM_TARGET) begin
			gen_source(src_idx);
			src_idx++;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim[i]) send_item(stim[i]);
		s_axis_tvalid <= 1'b0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input transfers in %0d sources, %0d tokens compared",
			sb.inputs_seen, n_sources, sb.tokens_seen);
		$display("keywords %0d/%0d, numbers %0d, unknown %0d, eof %0d, one long output hold-off",
			sb.kind_count[KIND_KW_MAT], sb.kind_count[KIND_KW_MUL],
			sb.kind_count[KIND_NUMBER], sb.kind_count[KIND_UNKNOWN], sb.kind_count[KIND_EOF]);
		if (sb.mismatches == 0)
			$display("matrix_dsl_tokenizer_unit_tb: PASS");
		else
			$display("matrix_dsl_tokenizer_unit_tb: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/mdt_pkg.sv
rtl/mdt_front.sv
rtl/mdt_fifo.sv
rtl/mdt_back.sv
rtl/matrix_dsl_tokenizer_unit.sv
rtl/mdt_checker.sv
tb/matrix_dsl_tokenizer_unit_tb.sv
